>>> rtl/core/button_press_classifier_top_assert.svh
// Assertion macros for the button press classifier top level.
// Depends on nothing; included by button_press_classifier_top.sv.
`ifndef BUTTON_PRESS_CLASSIFIER_TOP_ASSERT_SVH
`define BUTTON_PRESS_CLASSIFIER_TOP_ASSERT_SVH

// same-cycle implication
`define BPC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/bpc_pkg.sv
// Shared widths, reset values and codes for the button press classifier.
// Depends on nothing; used by the channel interfaces and the top level.
package bpc_pkg;

    localparam int NUM_BUTTONS = 3;

    localparam int LEVEL_W    = 3;
    localparam int DEBOUNCE_W = 11;
    localparam int POLL_W     = 11;
    localparam int LONG_W     = 12;
    localparam int DUR_W      = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int BTN_W      = 2;
    localparam int KIND_W     = 2;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 11'd70;
    localparam logic [POLL_W-1:0]     POLL_RESET     = 11'd20;
    localparam logic [LONG_W-1:0]     LONG_RESET     = 12'd1500;
    localparam logic [DUR_W-1:0]      DUR_MAX        = 13'd8191;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POLL     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG     = 2'd2;

    localparam logic [BTN_W-1:0] BTN_NONE  = 2'd0;
    localparam logic [BTN_W-1:0] BTN_LEFT  = 2'd1;
    localparam logic [BTN_W-1:0] BTN_ENTER = 2'd2;
    localparam logic [BTN_W-1:0] BTN_RIGHT = 2'd3;

    localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SHORT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LONG  = 2'd2;

endpackage

>>> rtl/core/bpc_tick_if.sv
// Input channel: one 1 ms tick with button levels and a read strobe.
// Depends on bpc_pkg.
interface bpc_tick_if
    import bpc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] button_levels;
    logic               read_event;

    modport source (output valid, output button_levels, output read_event, input ready);
    modport sink   (input valid, input button_levels, input read_event, output ready);
endinterface

>>> rtl/core/bpc_event_if.sv
// Result channel: the event latch as seen after one tick.
// Depends on bpc_pkg.
interface bpc_event_if
    import bpc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              event_pending;
    logic [BTN_W-1:0]  event_button;
    logic [KIND_W-1:0] event_kind;

    modport source (output valid, output event_pending, output event_button,
                    output event_kind, input ready);
    modport sink   (input valid, input event_pending, input event_button,
                    input event_kind, output ready);
endinterface

>>> rtl/core/button_press_classifier_top.sv
// Button press classifier: debounce, short and long press detection for three buttons.
// Depends on bpc_pkg, bpc_tick_if, bpc_event_if and button_press_classifier_top_assert.svh.
//
// One tick is taken every clock cycle while the result side does not stall. A tick is
// captured in an input register, the press state and event latch are updated by one
// pass of counter and compare logic, and the result then lands in an output register.
// A stall on the result side holds both registers; there is no start-up sweep, so
// ticks are taken from the first cycle after reset. Configuration writes go straight
// into the three interval registers and must be made while no tick is in flight.
module button_press_classifier_top
    import bpc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    bpc_tick_if.sink              i_tick,
    bpc_event_if.source           o_event
);

    `include "button_press_classifier_top_assert.svh"

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_DEBOUNCE = 2'd1,
        PH_POLL     = 2'd2
    } t_phase;

    logic [DEBOUNCE_W-1:0] r_debounce_ms;
    logic [POLL_W-1:0]     r_poll_ms;
    logic [LONG_W-1:0]     r_long_ms;

    logic                  r_s1_valid;
    logic [LEVEL_W-1:0]    r_s1_levels;
    logic                  r_s1_read;

    t_phase                r_phase,        n_phase;
    logic [LEVEL_W-1:0]    r_prev_levels,  n_prev_levels;
    logic [BTN_W-1:0]      r_active,       n_active;
    logic [POLL_W-1:0]     r_timer,        n_timer;
    logic [DUR_W-1:0]      r_duration,     n_duration;
    logic [BTN_W-1:0]      r_latch_button, n_latch_button;
    logic [KIND_W-1:0]     r_latch_kind,   n_latch_kind;

    logic                  r_out_valid;
    logic                  r_out_pending;
    logic [BTN_W-1:0]      r_out_button;
    logic [KIND_W-1:0]     r_out_kind;

    logic                  w_accept;
    logic                  w_advance;
    logic [LEVEL_W-1:0]    w_falling;
    logic                  w_down;
    logic                  w_expired;
    logic [DUR_W:0]        w_sum;
    logic [BTN_W-1:0]      w_res_button;
    logic [KIND_W-1:0]     w_res_kind;

    assign w_advance      = r_s1_valid && (!r_out_valid || o_event.ready);
    assign i_tick.ready   = !r_s1_valid || w_advance;
    assign w_accept       = i_tick.valid && i_tick.ready;

    assign o_event.valid         = r_out_valid;
    assign o_event.event_pending = r_out_pending;
    assign o_event.event_button  = r_out_button;
    assign o_event.event_kind    = r_out_kind;

    assign w_falling = r_prev_levels & ~r_s1_levels & LEVEL_W'((1 << NUM_BUTTONS) - 1);
    assign w_expired = r_timer <= POLL_W'(1);
    assign w_sum     = {1'b0, r_duration} + (DUR_W + 1)'(r_poll_ms);

    always_comb begin
        case (r_active)
            BTN_LEFT:  w_down = !r_s1_levels[0];
            BTN_ENTER: w_down = !r_s1_levels[1];
            BTN_RIGHT: w_down = !r_s1_levels[2];
            default:   w_down = 1'b0;
        endcase
    end

    always_comb begin
        n_phase        = r_phase;
        n_active       = r_active;
        n_timer        = r_timer;
        n_duration     = r_duration;
        w_res_button   = r_latch_button;
        w_res_kind     = r_latch_kind;
        n_prev_levels  = r_s1_levels;
        unique case (r_phase)
            PH_DEBOUNCE: begin
                if (!w_expired) begin
                    n_timer = r_timer - POLL_W'(1);
                end else if (w_down) begin
                    n_duration = DUR_W'(r_debounce_ms);
                    n_timer    = r_poll_ms;
                    n_phase    = PH_POLL;
                end else begin
                    n_phase = PH_IDLE;
                end
            end
            PH_POLL: begin
                if (!w_expired) begin
                    n_timer = r_timer - POLL_W'(1);
                end else if (!w_down) begin
                    if (r_duration != '0) begin
                        w_res_kind   = KIND_SHORT;
                        w_res_button = r_active;
                    end
                    n_phase = PH_IDLE;
                end else if (r_duration < DUR_W'(r_long_ms)) begin
                    n_duration = w_sum[DUR_W] ? DUR_MAX : w_sum[DUR_W-1:0];
                    n_timer    = r_poll_ms;
                end else begin
                    w_res_kind   = KIND_LONG;
                    w_res_button = r_active;
                    n_phase      = PH_IDLE;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                if (w_falling != '0) begin
                    if (w_falling[2]) begin
                        n_active = BTN_RIGHT;
                    end else if (w_falling[1]) begin
                        n_active = BTN_ENTER;
                    end else begin
                        n_active = BTN_LEFT;
                    end
                    n_duration = '0;
                    n_timer    = r_debounce_ms;
                    n_phase    = PH_DEBOUNCE;
                end
            end
        endcase
        n_latch_button = r_s1_read ? BTN_NONE  : w_res_button;
        n_latch_kind   = r_s1_read ? KIND_NONE : w_res_kind;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ms  <= DEBOUNCE_RESET;
            r_poll_ms      <= POLL_RESET;
            r_long_ms      <= LONG_RESET;
            r_s1_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_phase        <= PH_IDLE;
            r_prev_levels  <= '1;
            r_active       <= BTN_NONE;
            r_timer        <= '0;
            r_duration     <= '0;
            r_latch_button <= BTN_NONE;
            r_latch_kind   <= KIND_NONE;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_DEBOUNCE: r_debounce_ms <= i_cfg_data[DEBOUNCE_W-1:0];
                    CFG_POLL:     r_poll_ms     <= i_cfg_data[POLL_W-1:0];
                    CFG_LONG:     r_long_ms     <= i_cfg_data[LONG_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (w_accept) begin
                r_s1_valid <= 1'b1;
            end else if (w_advance) begin
                r_s1_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid    <= 1'b1;
                r_phase        <= n_phase;
                r_prev_levels  <= n_prev_levels;
                r_active       <= n_active;
                r_timer        <= n_timer;
                r_duration     <= n_duration;
                r_latch_button <= n_latch_button;
                r_latch_kind   <= n_latch_kind;
            end else if (o_event.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_levels <= i_tick.button_levels;
            r_s1_read   <= i_tick.read_event;
        end
        if (w_advance) begin
            r_out_pending <= (w_res_kind != KIND_NONE);
            r_out_button  <= w_res_button;
            r_out_kind    <= w_res_kind;
        end
    end

    `BPC_ASSERT_NOW(a_event_has_button, i_clk, i_rst_n,
        r_out_valid && (r_out_kind != KIND_NONE), r_out_button != BTN_NONE,
        "event reported without a button")
    `BPC_ASSERT_NOW(a_armed_has_button, i_clk, i_rst_n,
        r_phase != PH_IDLE, r_active != BTN_NONE,
        "press tracking active without a button")
    `BPC_ASSERT_NEXT(a_state_holds_on_stall, i_clk, i_rst_n,
        !w_advance, $stable(r_phase) && $stable(r_timer) && $stable(r_latch_kind),
        "press state moved without a tick")
    `BPC_ASSERT_NEXT(a_read_clears_latch, i_clk, i_rst_n,
        w_advance && r_s1_read, r_latch_kind == KIND_NONE && r_latch_button == BTN_NONE,
        "event latch not cleared by read")

endmodule
